FILE: src/mrv_pkg.sv
// Package for the Modbus RTU request validator: register map, verdict and
// exception codes, frame snapshot and config structs, CRC-16 byte update.
// No dependencies.
`default_nettype none
package mrv_pkg;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [7:0] SLAVE_ADDR = 8'h01;
	localparam logic [7:0] EXC_FLAG = 8'h80;
	localparam logic [15:0] COIL_ON = 16'hFF00;
	localparam logic [15:0] COIL_OFF = 16'h0000;
	localparam logic [15:0] HOLD_MIN = 16'd4000;
	localparam logic [15:0] HOLD_MAX = 16'd20000;

	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_SWITCH_COUNT = 3'd0;
	localparam logic [2:0] REG_RELAY_COUNT = 3'd1;
	localparam logic [2:0] REG_INPUT_COUNT = 3'd2;
	localparam logic [2:0] REG_HOLDING_COUNT = 3'd3;
	localparam logic [2:0] REG_RELAY_BASE = 3'd4;
	localparam logic [15:0] RELAY_BASE_RESET = 16'd100;

	localparam logic [7:0] FC_READ_COILS = 8'd1;
	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FC_READ_INPUT = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL = 8'd5;
	localparam logic [7:0] FC_WRITE_HOLDING = 8'd6;

	localparam logic [2:0] EXC_NONE = 3'd0;
	localparam logic [2:0] EXC_ILLEGAL_FUNCTION = 3'd1;
	localparam logic [2:0] EXC_ILLEGAL_ADDRESS = 3'd2;
	localparam logic [2:0] EXC_ILLEGAL_VALUE = 3'd3;
	localparam logic [2:0] EXC_DEVICE_FAILURE = 3'd4;

	typedef enum logic [2:0] {
		V_OK = 3'd0,
		V_WRONG_SLAVE = 3'd1,
		V_CRC_BAD = 3'd2,
		V_DEVICE_FAULT = 3'd3,
		V_BAD_FUNCTION = 3'd4,
		V_BAD_ADDRESS = 3'd5,
		V_BAD_VALUE = 3'd6
	} verdict_t;

	typedef struct packed {
		logic [5:0] switch_count;
		logic [4:0] relay_count;
		logic [5:0] input_count;
		logic [4:0] holding_count;
		logic [15:0] relay_base;
	} mrv_cfg_t;

	typedef struct packed {
		logic addr_ok;
		logic crc_bad;
		logic [7:0] function_code;
		logic [15:0] start_address;
		logic [15:0] data_word;
		logic [15:0] part_crc;
	} mrv_frame_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (v[0]) begin
				v = (v >> 1) ^ CRC_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

	localparam logic [15:0] REPLY_SEED = crc_feed(CRC_SEED, SLAVE_ADDR);

endpackage
`default_nettype wire

FILE: src/mrv_req_if.sv
// Request channel: one frame byte and its end mark per transfer.
// No dependencies.
`default_nettype none
interface mrv_req_if;
	logic valid;
	logic ready;
	logic [7:0] frame_byte;
	logic frame_end;
	modport source(output valid, output frame_byte, output frame_end, input ready);
	modport sink(input valid, input frame_byte, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: src/mrv_res_if.sv
// Result channel: verdict, exception code, decoded header and reply CRC.
// No dependencies.
`default_nettype none
interface mrv_res_if;
	logic valid;
	logic ready;
	logic [2:0] verdict;
	logic [2:0] exc_code;
	logic [7:0] function_code;
	logic [15:0] start_address;
	logic [15:0] data_word;
	logic [15:0] reply_crc;
	modport source(output valid, output verdict, output exc_code, output function_code,
		output start_address, output data_word, output reply_crc, input ready);
	modport sink(input valid, input verdict, input exc_code, input function_code,
		input start_address, input data_word, input reply_crc, output ready);
endinterface
`default_nettype wire

FILE: src/mrv_cfg_regs.sv
// APB configuration registers of the request validator.
// Depends on mrv_pkg.
`default_nettype none
module mrv_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [mrv_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output mrv_pkg::mrv_cfg_t cfg
);
	import mrv_pkg::*;

	mrv_cfg_t cfg_q;
	logic [2:0] idx;
	logic wr_en;

	assign idx = paddr[PADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.switch_count <= '0;
			cfg_q.relay_count <= '0;
			cfg_q.input_count <= '0;
			cfg_q.holding_count <= '0;
			cfg_q.relay_base <= RELAY_BASE_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_SWITCH_COUNT: cfg_q.switch_count <= pwdata[5:0];
				REG_RELAY_COUNT: cfg_q.relay_count <= pwdata[4:0];
				REG_INPUT_COUNT: cfg_q.input_count <= pwdata[5:0];
				REG_HOLDING_COUNT: cfg_q.holding_count <= pwdata[4:0];
				REG_RELAY_BASE: cfg_q.relay_base <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SWITCH_COUNT: prdata = {26'd0, cfg_q.switch_count};
			REG_RELAY_COUNT: prdata = {27'd0, cfg_q.relay_count};
			REG_INPUT_COUNT: prdata = {26'd0, cfg_q.input_count};
			REG_HOLDING_COUNT: prdata = {27'd0, cfg_q.holding_count};
			REG_RELAY_BASE: prdata = {16'd0, cfg_q.relay_base};
			default: prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/mrv_frame_rx.sv
// Frame receiver: byte count, running CRC-16, header capture and the
// snapshot register handed to the checker on the final byte.
// Depends on mrv_pkg and mrv_req_if.
`default_nettype none
module mrv_frame_rx #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	mrv_req_if.sink req,
	input wire logic advance,
	output logic valid_s1,
	output mrv_pkg::mrv_frame_t frame_s1
);
	import mrv_pkg::*;

	localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);

	logic [CW-1:0] cnt_q, cnt_nxt;
	logic [15:0] crc_q, crc_nxt;
	logic [7:0] hdr_q [6];
	logic [7:0] hdr_nxt [6];
	logic accept;
	mrv_frame_t snap;

	assign req.ready = !valid_s1 || advance;
	assign accept = req.valid && req.ready;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			hdr_nxt[i] = (cnt_q == CW'(i)) ? req.frame_byte : hdr_q[i];
		end
		cnt_nxt = (cnt_q <= MAX_CNT) ? cnt_q + 1'b1 : cnt_q;
		crc_nxt = crc_feed(crc_q, req.frame_byte);
		snap.addr_ok = (hdr_nxt[0] == SLAVE_ADDR);
		snap.crc_bad = (crc_nxt != 16'd0) || (cnt_nxt > MAX_CNT);
		snap.function_code = hdr_nxt[1];
		snap.start_address = {hdr_nxt[2], hdr_nxt[3]};
		snap.data_word = {hdr_nxt[4], hdr_nxt[5]};
		snap.part_crc = crc_feed(REPLY_SEED, hdr_nxt[1] + EXC_FLAG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= CRC_SEED;
			for (int i = 0; i < 6; i++) begin
				hdr_q[i] <= '0;
			end
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (req.frame_end) begin
					cnt_q <= '0;
					crc_q <= CRC_SEED;
					for (int i = 0; i < 6; i++) begin
						hdr_q[i] <= '0;
					end
				end else begin
					cnt_q <= cnt_nxt;
					crc_q <= crc_nxt;
					hdr_q <= hdr_nxt;
				end
			end
			if (accept && req.frame_end) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.frame_end) begin
			frame_s1 <= snap;
		end
	end
endmodule
`default_nettype wire

FILE: src/mrv_check.sv
// Request checker: verdict, exception code and reply CRC from the frame
// snapshot, held in the result register. Depends on mrv_pkg and mrv_res_if.
`default_nettype none
module mrv_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire mrv_pkg::mrv_cfg_t cfg,
	input wire logic valid_s1,
	input wire mrv_pkg::mrv_frame_t frame_s1,
	output logic advance,
	mrv_res_if.source res
);
	import mrv_pkg::*;

	logic valid_q;
	verdict_t verdict_q, vd, chk;
	logic [2:0] code_q, code;
	logic [7:0] fc_q;
	logic [15:0] sa_q, dw_q, rcrc_q, rcrc;
	logic signed [18:0] sa, dw, s, sw, ro, ir, hr, rb, ro_rb;
	logic [7:0] fc;

	assign advance = valid_s1 && (!valid_q || res.ready);

	always_comb begin
		fc = frame_s1.function_code;
		sa = signed'({3'd0, frame_s1.start_address});
		dw = signed'({3'd0, frame_s1.data_word});
		s = sa + dw;
		sw = signed'({13'd0, cfg.switch_count});
		ro = signed'({14'd0, cfg.relay_count});
		ir = signed'({13'd0, cfg.input_count});
		hr = signed'({14'd0, cfg.holding_count});
		rb = signed'({3'd0, cfg.relay_base});
		ro_rb = ro + rb;
		chk = V_OK;
		case (fc)
			FC_READ_COILS: begin
				if ((sa > rb) ? (ro == 19'sd0) : (sw == 19'sd0)) begin
					chk = V_DEVICE_FAULT;
				end else if ((sa > sw - 19'sd1 && sa < rb) || sa > ro_rb - 19'sd1) begin
					chk = V_BAD_ADDRESS;
				end else if ((s > sw && s < ro_rb) || s > ro_rb) begin
					chk = V_BAD_VALUE;
				end
			end
			FC_READ_HOLDING, FC_WRITE_HOLDING: begin
				if (hr == 19'sd0) begin
					chk = V_DEVICE_FAULT;
				end else if (sa > hr - 19'sd1) begin
					chk = V_BAD_ADDRESS;
				end else if (fc == FC_READ_HOLDING) begin
					if (s > hr) begin
						chk = V_BAD_VALUE;
					end
				end else if (frame_s1.data_word < HOLD_MIN || frame_s1.data_word > HOLD_MAX) begin
					chk = V_BAD_VALUE;
				end
			end
			FC_READ_INPUT: begin
				if (ir == 19'sd0) begin
					chk = V_DEVICE_FAULT;
				end else if (sa > ir - 19'sd1) begin
					chk = V_BAD_ADDRESS;
				end else if (s > ir) begin
					chk = V_BAD_VALUE;
				end
			end
			FC_WRITE_COIL: begin
				if (ro == 19'sd0) begin
					chk = V_DEVICE_FAULT;
				end else if (sa < rb || sa > ro_rb - 19'sd1) begin
					chk = V_BAD_ADDRESS;
				end else if (frame_s1.data_word != COIL_OFF && frame_s1.data_word != COIL_ON) begin
					chk = V_BAD_VALUE;
				end
			end
			default: chk = V_BAD_FUNCTION;
		endcase

		if (!frame_s1.addr_ok) begin
			vd = V_WRONG_SLAVE;
		end else if (frame_s1.crc_bad) begin
			vd = V_CRC_BAD;
		end else begin
			vd = chk;
		end

		case (vd)
			V_DEVICE_FAULT: code = EXC_DEVICE_FAILURE;
			V_BAD_FUNCTION: code = EXC_ILLEGAL_FUNCTION;
			V_BAD_ADDRESS: code = EXC_ILLEGAL_ADDRESS;
			V_BAD_VALUE: code = EXC_ILLEGAL_VALUE;
			default: code = EXC_NONE;
		endcase

		case (code)
			EXC_ILLEGAL_FUNCTION: rcrc = crc_feed(frame_s1.part_crc, {5'd0, EXC_ILLEGAL_FUNCTION});
			EXC_ILLEGAL_ADDRESS: rcrc = crc_feed(frame_s1.part_crc, {5'd0, EXC_ILLEGAL_ADDRESS});
			EXC_ILLEGAL_VALUE: rcrc = crc_feed(frame_s1.part_crc, {5'd0, EXC_ILLEGAL_VALUE});
			EXC_DEVICE_FAILURE: rcrc = crc_feed(frame_s1.part_crc, {5'd0, EXC_DEVICE_FAILURE});
			default: rcrc = 16'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_q <= vd;
			code_q <= code;
			fc_q <= fc;
			sa_q <= frame_s1.start_address;
			dw_q <= frame_s1.data_word;
			rcrc_q <= rcrc;
		end
	end

	assign res.valid = valid_q;
	assign res.verdict = verdict_q;
	assign res.exc_code = code_q;
	assign res.function_code = fc_q;
	assign res.start_address = sa_q;
	assign res.data_word = dw_q;
	assign res.reply_crc = rcrc_q;
endmodule
`default_nettype wire

FILE: src/modbus_rtu_request_validator_unit.sv
// Modbus RTU request validator, top level.
// Takes one request byte per cycle unless held off by back-pressure from
// the result channel; the CRC is updated combinationally for each byte.
// The final byte's result passes the frame snapshot and result registers.
// Asynchronous active-low reset clears the frame state, both valid flags and
// the configuration registers (relay base to 100, counts to 0).
`default_nettype none
module modbus_rtu_request_validator_unit #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [mrv_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	mrv_req_if.sink req,
	mrv_res_if.source res
);
	import mrv_pkg::*;

	mrv_cfg_t cfg;
	mrv_frame_t frame_s1;
	logic valid_s1;
	logic advance;

	mrv_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	mrv_frame_rx #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_rx (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.advance(advance),
		.valid_s1(valid_s1),
		.frame_s1(frame_s1)
	);

	mrv_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.valid_s1(valid_s1),
		.frame_s1(frame_s1),
		.advance(advance),
		.res(res)
	);
endmodule
`default_nettype wire
